>>> rtl/assert_macros.svh
// Assertion macros used by the checker file sprd_checker.sv.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define SPR_PROP(prop) @(posedge clk_i) disable iff (!rst_ni) prop

// Labeled concurrent assertion that reports through $error.
`define SPR_ASSERT(lbl, prop) \
  lbl: assert property (`SPR_PROP(prop)) else $error("sprd assertion failed");

`endif

>>> rtl/sprd_pkg.sv
// Shared types, codes and the color ROM of the sprite tile row decoder.
// No dependencies.
package sprd_pkg;

  localparam int unsigned SprSlotsDefault = 64;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 6;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_DECODE    = 1'b1
  } sprd_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TALL_MODE  = 2'd0,
    CFG_HIGH_PAT   = 2'd1,
    CFG_SPRITES_ON = 2'd2,
    CFG_SLOT_ROT   = 2'd3
  } sprd_cfg_e;

  typedef struct packed {
    logic       opcode;
    logic [5:0] slot_number;
    logic [7:0] tile_number;
    logic [7:0] attribute_byte;
    logic [3:0] source_row;
    logic [7:0] plane_low;
    logic [7:0] plane_high;
    logic [3:0] palette_slot;
    logic [5:0] palette_color;
  } sprd_req_t;

  typedef struct packed {
    logic [8:0]  sheet_x;
    logic [3:0]  sheet_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] fetch_address;
    logic        last_pixel;
  } sprd_pix_t;

  localparam logic [23:0] ColorRom [64] = '{
    24'h808080, 24'h003DA6, 24'h0012B0, 24'h440096,
    24'hA1005E, 24'hC70028, 24'hBA0600, 24'h8C1700,
    24'h5C2F00, 24'h104500, 24'h054A00, 24'h00472E,
    24'h004166, 24'h000000, 24'h050505, 24'h050505,
    24'hC7C7C7, 24'h0077FF, 24'h2155FF, 24'h8237FA,
    24'hEB2FB5, 24'hFF2950, 24'hFF2200, 24'hD63200,
    24'hC46200, 24'h358000, 24'h058F00, 24'h008A55,
    24'h0099CC, 24'h212121, 24'h090909, 24'h090909,
    24'hFFFFFF, 24'h0FD7FF, 24'h69A2FF, 24'hD480FF,
    24'hFF45F3, 24'hFF618B, 24'hFF8833, 24'hFF9C12,
    24'hFABC20, 24'h9FE30E, 24'h2BF035, 24'h0CF0A4,
    24'h05FBFF, 24'h5E5E5E, 24'h0D0D0D, 24'h0D0D0D,
    24'hFFFFFF, 24'hA6FCFF, 24'hB3ECFF, 24'hDAABEB,
    24'hFFA8F9, 24'hFFABB3, 24'hFFD2B0, 24'hFFEFA6,
    24'hFFF79C, 24'hD7E895, 24'hA6EDAF, 24'hA2F2DA,
    24'h99FFFC, 24'hDDDDDD, 24'h111111, 24'h111111
  };

  function automatic logic [23:0] color_lookup(input logic [5:0] id);
    return ColorRom[id];
  endfunction

endpackage

>>> rtl/sprd_ifs.sv
// Valid/ready channel interfaces for requests and pixels.
// Depends on sprd_pkg.
interface sprd_req_if import sprd_pkg::*; ();
  logic      valid;
  logic      ready;
  sprd_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sprd_pix_if import sprd_pkg::*; ();
  logic      valid;
  logic      ready;
  sprd_pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sprite_tile_row_decoder.sv
// Sprite tile row decoder: a loaded decode row gives eight pixels, one per cycle unless output stalls.
// A decode request passes the row stage, the lookup stage and the output register.
// New requests are taken while the row stage is idle or as the last pixel of a row issues.
// Rows issue through a 16x6 palette RAM (registered read) then the color ROM.
// Reset (async, active low) clears control, config and palette valid bits; sprites-on resets to 1.
// Depends on sprd_pkg and sprd_ifs.
module sprite_tile_row_decoder import sprd_pkg::*; #(
  parameter int unsigned SPRITE_SLOTS = SprSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sprd_req_if.sink            req_i,
  sprd_pix_if.source          pix_o
);

  localparam int unsigned ColW       = $clog2(SPRITE_SLOTS);
  localparam int unsigned SumW       = 7;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned Recip      = (1 << RecipShift) / SPRITE_SLOTS + 1;
  localparam int unsigned RecipW     = $clog2(Recip + 1);
  localparam int unsigned ProdW      = SumW + RecipW;

  // configuration
  logic       tall_q, hipat_q, on_q;
  logic [5:0] rot_q;

  // row stage
  logic          row_vld_q;
  logic [2:0]    cnt_q;
  logic [7:0]    plo_q, phi_q;
  logic          hflip_q;
  logic [1:0]    pal_q;
  logic [3:0]    y_q;
  logic [12:0]   addr_q;
  logic [SumW-1:0] sum_q;

  // palette RAM
  logic [5:0]  pal_mem_q [16];
  logic [15:0] pal_vld_q;
  logic [5:0]  rd_data_q;
  logic        rd_vld_q;

  // lookup stage
  logic            s1_vld_q;
  logic            s1_opaque_q;
  logic [2:0]      s1_pos_q;
  logic [3:0]      s1_y_q;
  logic [12:0]     s1_addr_q;
  logic            s1_last_q;
  logic [SumW-1:0] s1_sum_q;
  logic [SumW-1:0] s1_quo_q;

  // output register
  logic      pix_vld_q;
  sprd_pix_t pix_q, pix_d;

  logic            out_ready, s1_ready, issue, last_issue, accept;
  logic            is_dec, is_wr, load;
  logic [2:0]      bit_sel;
  logic [1:0]      pv;
  logic [3:0]      rd_addr;
  logic [ProdW-1:0] prod;
  logic [SumW-1:0] quo_d;
  logic            tbl_d;
  logic [7:0]      tile_d;
  logic [3:0]      y_d;
  logic [SumW-1:0] rem_a, rem_b;
  logic [ColW-1:0] column;
  logic [5:0]      rom_idx;
  logic [23:0]     rgb;

  assign out_ready  = !pix_vld_q || pix_o.ready;
  assign s1_ready   = !s1_vld_q || out_ready;
  assign issue      = row_vld_q && s1_ready;
  assign last_issue = issue && (cnt_q == 3'd7);
  assign req_i.ready = !row_vld_q || last_issue;
  assign accept     = req_i.valid && req_i.ready;
  assign is_dec     = accept && (req_i.data.opcode == OP_DECODE);
  assign is_wr      = accept && (req_i.data.opcode == OP_PAL_WRITE);
  assign load       = is_dec && (tall_q || !req_i.data.source_row[3]);

  always_comb begin
    tbl_d  = tall_q ? req_i.data.tile_number[0] : hipat_q;
    tile_d = tall_q ? {req_i.data.tile_number[7:1], req_i.data.source_row[3]}
                    : req_i.data.tile_number;
    if (!req_i.data.attribute_byte[7]) begin
      y_d = req_i.data.source_row;
    end else if (tall_q) begin
      y_d = 4'd15 - req_i.data.source_row;
    end else begin
      y_d = 4'd7 - req_i.data.source_row;
    end
  end

  assign bit_sel = 3'd7 - cnt_q;
  assign pv      = {phi_q[bit_sel], plo_q[bit_sel]};
  assign rd_addr = {pal_q, pv};
  assign prod    = ProdW'(sum_q) * ProdW'(Recip);
  assign quo_d   = SumW'(prod >> RecipShift);

  always_comb begin
    rem_a    = s1_sum_q - SumW'(s1_quo_q * SumW'(SPRITE_SLOTS));
    rem_b    = (rem_a >= SumW'(SPRITE_SLOTS)) ? rem_a - SumW'(SPRITE_SLOTS) : rem_a;
    column   = ColW'(rem_b);
    rom_idx  = rd_vld_q ? rd_data_q : 6'd0;
    rgb      = color_lookup(rom_idx);
    pix_d.sheet_x       = 9'({column, s1_pos_q});
    pix_d.sheet_y       = s1_y_q;
    pix_d.red           = s1_opaque_q ? rgb[23:16] : 8'h00;
    pix_d.green         = s1_opaque_q ? rgb[15:8] : 8'h00;
    pix_d.blue          = s1_opaque_q ? rgb[7:0] : 8'h00;
    pix_d.alpha         = s1_opaque_q ? 8'hFF : 8'h00;
    pix_d.fetch_address = s1_addr_q;
    pix_d.last_pixel    = s1_last_q;
  end

  assign pix_o.valid = pix_vld_q;
  assign pix_o.data  = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q    <= 1'b0;
      hipat_q   <= 1'b0;
      on_q      <= 1'b1;
      rot_q     <= 6'd0;
      row_vld_q <= 1'b0;
      cnt_q     <= 3'd0;
      pal_vld_q <= 16'd0;
      s1_vld_q  <= 1'b0;
      pix_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TALL_MODE:  tall_q  <= cfg_data_i[0];
          CFG_HIGH_PAT:   hipat_q <= cfg_data_i[0];
          CFG_SPRITES_ON: on_q    <= cfg_data_i[0];
          CFG_SLOT_ROT:   rot_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (load) begin
        row_vld_q <= 1'b1;
        cnt_q     <= 3'd0;
      end else if (issue) begin
        row_vld_q <= !last_issue;
        cnt_q     <= cnt_q + 3'd1;
      end
      if (is_wr) begin
        pal_vld_q[req_i.data.palette_slot] <= 1'b1;
      end
      if (issue) begin
        s1_vld_q <= 1'b1;
      end else if (out_ready) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_vld_q && out_ready) begin
        pix_vld_q <= 1'b1;
      end else if (pix_o.ready) begin
        pix_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plo_q   <= req_i.data.plane_low;
      phi_q   <= req_i.data.plane_high;
      hflip_q <= req_i.data.attribute_byte[6];
      pal_q   <= req_i.data.attribute_byte[1:0];
      y_q     <= y_d;
      addr_q  <= {tbl_d, tile_d, 1'b0, req_i.data.source_row[2:0]};
      sum_q   <= {1'b0, req_i.data.slot_number} + {1'b0, rot_q};
    end
    if (is_wr) begin
      pal_mem_q[req_i.data.palette_slot] <= req_i.data.palette_color;
    end
    if (issue) begin
      rd_data_q   <= pal_mem_q[rd_addr];
      rd_vld_q    <= pal_vld_q[rd_addr];
      s1_opaque_q <= on_q && (pv != 2'd0);
      s1_pos_q    <= hflip_q ? bit_sel : cnt_q;
      s1_y_q      <= y_q;
      s1_addr_q   <= addr_q;
      s1_last_q   <= (cnt_q == 3'd7);
      s1_sum_q    <= sum_q;
      s1_quo_q    <= quo_d;
    end
    if (s1_vld_q && out_ready) begin
      pix_q <= pix_d;
    end
  end

endmodule

>>> rtl/sprd_checker.sv
// Port-level checks on the pixel channel of the row decoder, bound to the top.
// Depends on sprd_pkg, sprd_ifs and assert_macros.svh.
`include "assert_macros.svh"

module sprd_checker import sprd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      pix_valid_i,
  input logic      pix_ready_i,
  input sprd_pix_t pix_data_i
);

  `SPR_ASSERT(a_pix_hold, pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_data_i))

  // pixels of one row leave without gaps and share address and row
  `SPR_ASSERT(a_row_burst, pix_valid_i && pix_ready_i && !pix_data_i.last_pixel |=> pix_valid_i && $stable(pix_data_i.fetch_address) && $stable(pix_data_i.sheet_y))

  `SPR_ASSERT(a_alpha, pix_valid_i |-> (pix_data_i.alpha == 8'hFF) || (pix_data_i.alpha == 8'h00 && pix_data_i.red == 8'h00 && pix_data_i.green == 8'h00 && pix_data_i.blue == 8'h00))

endmodule

bind sprite_tile_row_decoder sprd_checker u_sprd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_o.valid),
  .pix_ready_i (pix_o.ready),
  .pix_data_i  (pix_o.data)
);
